@@ src/packed_pixel_doubler_2x_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the packed pixel doubler.
// Both expect clk_i and rst_ni in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef PACKED_PIXEL_DOUBLER_2X_ASSERT_SVH
`define PACKED_PIXEL_DOUBLER_2X_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define PXD2X_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define PXD2X_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/pxd2x_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxd2x_pkg
// Shared types and constants of the packed pixel doubler.
// ----------------------------------------------------------------------------
package pxd2x_pkg;

  localparam int WORD_W          = 32;
  localparam int PIX_W           = 4;
  localparam int STORE_WORDS_DEF = 40;

  // source pixel depth codes; code 3 acts as 4 bits
  typedef enum logic [1:0] {
    DEPTH_1 = 2'd0,
    DEPTH_2 = 2'd1,
    DEPTH_4 = 2'd2
  } depth_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_REPLAY
  } state_e;

  typedef struct packed {
    logic take;
    logic line_end;
  } pack_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              full;
  } pack_sts_t;

endpackage

@@ src/pxd2x_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxd2x_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pxd2x_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pxd2x_pack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxd2x_pack
// Depth register and word assembly: doubles each pixel and packs it into
// the current 32-bit word, earlier pixel in the higher bits of each byte.
// ----------------------------------------------------------------------------
module pxd2x_pack (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_mode_i,
  input  pxd2x_pkg::pack_req_t         req_i,
  input  logic [pxd2x_pkg::PIX_W-1:0]  pixel_value_i,
  output pxd2x_pkg::pack_sts_t         sts_o
);
  import pxd2x_pkg::*;

  logic [1:0]        mode_q;
  logic [WORD_W-1:0] asm_q, asm_d;
  logic [3:0]        slot_q, slot_d;

  logic [4:0]        slots;
  logic              slot_ok;
  logic [3:0]        slot_e;
  logic [4:0]        slot_inc;
  logic [4:0]        shift;
  logic [7:0]        dbl;
  logic [WORD_W-1:0] word_next;
  logic              full;

  always_comb begin
    unique case (mode_q)
      DEPTH_1: slots = 5'd16;
      DEPTH_2: slots = 5'd8;
      default: slots = 5'd4;
    endcase
  end

  // an out of range slot restarts the word
  assign slot_ok  = {1'b0, slot_q} < slots;
  assign slot_e   = slot_ok ? slot_q : 4'd0;
  assign slot_inc = {1'b0, slot_e} + 5'd1;
  assign full     = slot_inc == slots;

  always_comb begin
    unique case (mode_q)
      DEPTH_1: begin
        dbl   = {6'd0, pixel_value_i[0], pixel_value_i[0]};
        shift = {slot_e[3:2], ~slot_e[1:0], 1'b0};
      end
      DEPTH_2: begin
        dbl   = {4'd0, pixel_value_i[1:0], pixel_value_i[1:0]};
        shift = {slot_e[2:1], ~slot_e[0], 2'b00};
      end
      default: begin
        dbl   = {pixel_value_i, pixel_value_i};
        shift = {slot_e[1:0], 3'b000};
      end
    endcase
  end

  assign word_next = (slot_ok ? asm_q : '0) | (WORD_W'(dbl) << shift);

  always_comb begin
    asm_d  = asm_q;
    slot_d = slot_q;
    if (cfg_we_i) begin
      asm_d  = '0;
      slot_d = '0;
    end else if (req_i.take) begin
      if (full || req_i.line_end) begin
        asm_d  = '0;
        slot_d = '0;
      end else begin
        asm_d  = word_next;
        slot_d = slot_inc[3:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= DEPTH_4;
      asm_q  <= '0;
      slot_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_mode_i;
      end
      asm_q  <= asm_d;
      slot_q <= slot_d;
    end
  end

  assign sts_o.word = word_next;
  assign sts_o.full = full;

endmodule

@@ src/packed_pixel_doubler_2x.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_pixel_doubler_2x
// 2x nearest neighbor upscaler for packed 1, 2 or 4 bit pixels.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one pixel per item plus a
// line end flag. Output channel (out_valid_o / out_stall_i) gives 32-bit
// words; second_copy_o marks replayed words, run_last_o the last word an
// input item causes. The config channel (cfg_valid_i / cfg_ready_o) sets
// the pixel depth and drops any partial word; it is always ready.
// A pixel that does not fill a word gives nothing; a pixel that fills one
// puts it in the output register the next cycle.
// On a line end the partial word goes out, a setup state follows, then
// the buffered line replays from the line RAM at one word per cycle while
// the receiver does not stall; the setup state issues the first read of
// the registered RAM read port.
// Input is stalled during the setup state and the replay, and while the
// output register is full and not drained. A receiver stall holds the
// current word and pauses the replay. Reset clears the control state and
// sets the depth to 4 bits; the line RAM needs no clearing since a line
// only reads words it wrote.
// ----------------------------------------------------------------------------
module packed_pixel_doubler_2x #(
  parameter int STORE_WORDS = pxd2x_pkg::STORE_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pxd2x_pkg::PIX_W-1:0]   pixel_value_i,
  input  logic                          line_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pxd2x_pkg::WORD_W-1:0]  packed_word_o,
  output logic                          second_copy_o,
  output logic                          run_last_o
);
  import pxd2x_pkg::*;

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int CW = $clog2(STORE_WORDS + 1);

  state_e state_q, state_d;

  logic [CW-1:0] words_q;
  logic [CW-1:0] words_after;
  logic [CW-1:0] rep_cnt_q;
  logic [AW-1:0] rep_idx_q;

  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic              out_copy_q;
  logic              out_last_q;

  pack_req_t         pack_req;
  pack_sts_t         pack_sts;
  logic              cfg_we;
  logic              out_free;
  logic              take;
  logic              emit;
  logic              store_en;
  logic              rep_last;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              load_rep;
  logic              idx_clr;
  logic              idx_inc;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign take       = in_valid_i && !in_stall_o;

  assign pack_req.take     = take;
  assign pack_req.line_end = line_end_i;

  pxd2x_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_mode_i    (cfg_data_i),
    .req_i         (pack_req),
    .pixel_value_i (pixel_value_i),
    .sts_o         (pack_sts)
  );

  assign emit        = take && (pack_sts.full || line_end_i);
  assign store_en    = emit && (words_q < CW'(STORE_WORDS));
  assign words_after = words_q + CW'(store_en);
  assign rep_last    = (CW'(rep_idx_q) + CW'(1)) == rep_cnt_q;

  pxd2x_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_WORDS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (words_q[AW-1:0]),
    .wdata_i (pack_sts.word),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && line_end_i) state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_REPLAY;
      end
      ST_REPLAY: begin
        if (out_free && rep_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs; the first read is issued in ST_START, after the line end,
  // so the word written on the line end is already in the RAM
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    load_rep  = 1'b0;
    idx_clr   = 1'b0;
    idx_inc   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_START: begin
        ram_re  = 1'b1;
        idx_clr = 1'b1;
      end
      ST_REPLAY: begin
        load_rep  = out_free;
        ram_re    = out_free && !rep_last;
        idx_inc   = out_free && !rep_last;
        ram_raddr = rep_idx_q + AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      words_q     <= '0;
      rep_cnt_q   <= '0;
      rep_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take && line_end_i) begin
        words_q   <= '0;
        rep_cnt_q <= words_after;
      end else if (store_en) begin
        words_q <= words_after;
      end
      if (idx_clr) begin
        rep_idx_q <= '0;
      end else if (idx_inc) begin
        rep_idx_q <= rep_idx_q + AW'(1);
      end
      if (emit || load_rep) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q <= pack_sts.word;
      out_copy_q <= 1'b0;
      out_last_q <= !line_end_i;
    end else if (load_rep) begin
      out_word_q <= ram_rdata;
      out_copy_q <= 1'b1;
      out_last_q <= rep_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_word_o = out_word_q;
  assign second_copy_o = out_copy_q;
  assign run_last_o    = out_last_q;

  `include "packed_pixel_doubler_2x_assert.svh"

  `PXD2X_ASSERT(a_rep_idx_in_line,
                (state_q == ST_REPLAY) |-> (CW'(rep_idx_q) < rep_cnt_q),
                "replay index past line")
  `PXD2X_ASSERT(a_words_bounded, words_q <= CW'(STORE_WORDS),
                "line word count overflow")
  `PXD2X_NEVER(a_write_in_replay, store_en && (state_q != ST_IDLE),
               "line RAM written during replay")
  `PXD2X_ASSERT(a_line_end_replays,
                (take && line_end_i) |=> (state_q == ST_START) && (rep_cnt_q != '0),
                "line end without replay")

endmodule

@@ tb/packed_pixel_doubler_2x_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_pixel_doubler_2x_test
// Self-checking bench for the 2x packed pixel doubler. A queue of pixel items
// and depth writes feeds a clocked driver; every accepted pixel runs through a
// local copy of the packing and line replay logic, and a clocked monitor
// compares each output word with the oldest predicted word. Both sides insert
// random wait cycles, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module packed_pixel_doubler_2x_test;
  import pxd2x_pkg::*;

  localparam int          STORE_WORDS  = STORE_WORDS_DEF;
  localparam logic [1:0]  DEPTH_SPARE  = 2'd3;  // unused code, acts as 4 bits
  localparam int          RAND_ITEMS   = 85;    // least number of pixels before the closing 1-bit line
  localparam int          SETTLE_CYC   = 6;
  localparam int          DRAIN_CYC    = 60;
  localparam int          HOLD_CYC     = 300;
  localparam int          HOLD_AFTER   = 24;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          MAX_REPORTS  = 10;

  typedef enum logic {ITEM_PIXEL, ITEM_DEPTH} item_kind_e;

  typedef struct {
    item_kind_e       kind;
    logic [1:0]       depth;
    logic [PIX_W-1:0] pix;
    logic             eol;
    int unsigned      gap;
  } stim_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              second;
    logic              last;
  } doubled_word_t;

  typedef enum logic [1:0] {DRV_LOAD, DRV_WAIT, DRV_QUIET, DRV_OFFER} drv_phase_e;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [1:0]        cfg_data = DEPTH_4;
  logic              in_valid = 1'b0;
  logic [PIX_W-1:0]  pixel_value = '0;
  logic              line_end = 1'b0;
  logic              rx_stall = 1'b0;
  logic              hold_off = 1'b0;
  wire               out_stall = rx_stall | hold_off;
  wire               cfg_ready;
  wire               in_stall;
  wire               out_valid;
  wire  [WORD_W-1:0] packed_word;
  wire               second_copy;
  wire               run_last;

  packed_pixel_doubler_2x dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .pixel_value_i (pixel_value),
    .line_end_i    (line_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .packed_word_o (packed_word),
    .second_copy_o (second_copy),
    .run_last_o    (run_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  logic [1:0]        dbl_depth;
  logic [WORD_W-1:0] dbl_asm;
  logic [WORD_W-1:0] dbl_line [STORE_WORDS];
  int unsigned       dbl_slot;
  int unsigned       dbl_words;
  doubled_word_t     run_q[$];
  doubled_word_t     expect_q[$];

  function automatic void flush_word();
    if (dbl_words < STORE_WORDS) begin
      dbl_line[dbl_words] = dbl_asm;
      dbl_words++;
    end
    run_q.push_back('{word: dbl_asm, second: 1'b0, last: 1'b0});
    dbl_asm  = '0;
    dbl_slot = 0;
  endfunction

  function automatic void set_depth(logic [1:0] code);
    dbl_depth = code;
    dbl_asm   = '0;
    dbl_slot  = 0;
  endfunction

  function automatic void double_pixel(logic [PIX_W-1:0] pix, logic eol);
    int unsigned      bits;
    int unsigned      wid;
    int unsigned      per_byte;
    int unsigned      slots;
    int unsigned      shift;
    logic [PIX_W-1:0] p;
    logic [7:0]       dbl;
    doubled_word_t    w;
    bits = (dbl_depth == DEPTH_1) ? 1 : (dbl_depth == DEPTH_2) ? 2 : 4;
    wid      = 2 * bits;
    per_byte = 8 / wid;
    slots    = WORD_W / wid;
    p   = pix & PIX_W'((1 << bits) - 1);
    dbl = 8'(p) | (8'(p) << bits);
    // earlier pixel goes to the high bits of its byte
    shift = (dbl_slot / per_byte) * 8 + (per_byte - 1 - dbl_slot % per_byte) * wid;
    dbl_asm |= WORD_W'(dbl) << shift;
    dbl_slot++;
    if (dbl_slot >= slots) flush_word();
    if (eol) begin
      if (dbl_slot != 0) flush_word();
      for (int i = 0; i < dbl_words; i++)
        run_q.push_back('{word: dbl_line[i], second: 1'b1, last: 1'b0});
      dbl_words = 0;
      dbl_asm   = '0;
      dbl_slot  = 0;
    end
    while (run_q.size() > 0) begin
      w = run_q.pop_front();
      w.last = (run_q.size() == 0);
      expect_q.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  stim_item_t  pend_q[$];
  int unsigned n_pixels;
  logic        tx_burst;

  task automatic add_pixel(logic [PIX_W-1:0] pix, logic eol);
    stim_item_t it;
    it.kind  = ITEM_PIXEL;
    it.depth = DEPTH_4;
    it.pix   = pix;
    it.eol   = eol;
    it.gap   = tx_burst ? 0 : $urandom_range(0, 15);
    pend_q.push_back(it);
    n_pixels++;
    if (n_pixels % 25 == 0) tx_burst = ~tx_burst;
  endtask

  task automatic add_depth(logic [1:0] code);
    stim_item_t it;
    it.kind  = ITEM_DEPTH;
    it.depth = code;
    it.pix   = '0;
    it.eol   = 1'b0;
    it.gap   = 0;
    pend_q.push_back(it);
  endtask

  // ---------------------------------------------------------------- driver
  drv_phase_e  drv_phase;
  stim_item_t  cur;
  int unsigned gap_left;
  int unsigned quiet_cnt;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      drv_phase = DRV_LOAD;
      gap_left  = 0;
      quiet_cnt = 0;
      cur       = '{kind: ITEM_PIXEL, depth: DEPTH_4, pix: '0, eol: 1'b0, gap: 0};
      dbl_depth = DEPTH_4;
      dbl_asm   = '0;
      dbl_slot  = 0;
      dbl_words = 0;
      in_valid    <= 1'b0;
      cfg_valid   <= 1'b0;
      pixel_value <= '0;
      line_end    <= 1'b0;
      cfg_data    <= DEPTH_4;
    end else begin
      if (drv_phase == DRV_OFFER) begin
        if (cur.kind == ITEM_DEPTH && cfg_valid && cfg_ready) begin
          set_depth(cur.depth);
          drv_phase = DRV_LOAD;
        end else if (cur.kind == ITEM_PIXEL && in_valid && !in_stall) begin
          double_pixel(cur.pix, cur.eol);
          drv_phase = DRV_LOAD;
        end
      end
      if (drv_phase == DRV_LOAD && pend_q.size() > 0) begin
        cur       = pend_q.pop_front();
        gap_left  = cur.gap;
        quiet_cnt = 0;
        drv_phase = (cur.kind == ITEM_DEPTH) ? DRV_QUIET : DRV_WAIT;
      end
      // depth writes only once every word is out and the block has settled
      if (drv_phase == DRV_QUIET) begin
        quiet_cnt = (expect_q.size() == 0) ? quiet_cnt + 1 : 0;
        if (quiet_cnt > SETTLE_CYC) drv_phase = DRV_OFFER;
      end else if (drv_phase == DRV_WAIT) begin
        if (gap_left == 0) drv_phase = DRV_OFFER;
        else gap_left--;
      end
      in_valid    <= (drv_phase == DRV_OFFER) && (cur.kind == ITEM_PIXEL);
      cfg_valid   <= (drv_phase == DRV_OFFER) && (cur.kind == ITEM_DEPTH);
      pixel_value <= cur.pix;
      line_end    <= cur.eol;
      cfg_data    <= cur.depth;
    end
  end

  // ---------------------------------------------------------------- monitor
  int unsigned mismatch_cnt = 0;
  int unsigned words_seen;
  int unsigned rx_wait;
  logic        rx_burst;

  always @(posedge clk or negedge rst_n) begin
    doubled_word_t e;
    if (!rst_n) begin
      rx_wait    = 0;
      rx_burst   = 1'b0;
      words_seen <= 0;
      rx_stall   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: unexpected word %h second=%b last=%b", $realtime,
                     packed_word, second_copy, run_last);
        end else begin
          e = expect_q.pop_front();
          if (packed_word !== e.word || second_copy !== e.second || run_last !== e.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("%0t: word %h second=%b last=%b, expected %h second=%b last=%b",
                       $realtime, packed_word, second_copy, run_last,
                       e.word, e.second, e.last);
          end
        end
        words_seen <= words_seen + 1;
        if (words_seen % 32 == 31) rx_burst = ~rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 15);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      rx_stall <= (rx_wait != 0);
    end
  end

  // one long receiver hold-off so the block fills and stalls its input
  int unsigned hold_cnt;
  logic        hold_done;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_off  <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_off) begin
      if (hold_cnt == HOLD_CYC - 1) begin
        hold_off  <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_cnt <= hold_cnt + 1;
    end else if (!hold_done && words_seen >= HOLD_AFTER) begin
      hold_off <= 1'b1;
      hold_cnt <= 0;
    end
  end

  int unsigned cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("packed_pixel_doubler_2x_test: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int unsigned len;
    n_pixels  = 0;
    tx_burst  = 1'b0;

    // reset depth (4 bits): full word, partial word, replay
    add_pixel(4'hF, 1'b0);
    add_pixel(4'h0, 1'b0);
    add_pixel(4'hA, 1'b0);
    add_pixel(4'h5, 1'b0);
    add_pixel(4'hF, 1'b1);
    // 1 bit: only bit 0 counts
    add_depth(DEPTH_1);
    add_pixel(4'h1, 1'b0);
    add_pixel(4'h0, 1'b0);
    add_pixel(4'hF, 1'b0);
    add_pixel(4'hE, 1'b1);
    add_depth(DEPTH_2);
    add_pixel(4'h3, 1'b0);
    add_pixel(4'hC, 1'b0);
    add_pixel(4'h2, 1'b0);
    add_pixel(4'hD, 1'b1);
    // unused depth code behaves as 4 bits
    add_depth(DEPTH_SPARE);
    add_pixel(4'hF, 1'b0);
    add_pixel(4'h9, 1'b1);
    // depth change mid-line drops the partial word, keeps stored ones
    add_depth(DEPTH_4);
    add_pixel(4'h1, 1'b0);
    add_pixel(4'h2, 1'b0);
    add_pixel(4'h3, 1'b0);
    add_pixel(4'h4, 1'b0);
    add_pixel(4'h5, 1'b0);
    add_depth(DEPTH_2);
    add_pixel(4'h7, 1'b0);
    add_pixel(4'hB, 1'b1);
    // one-pixel line
    add_pixel(4'h6, 1'b1);

    while (n_pixels < RAND_ITEMS) begin
      if ($urandom_range(0, 3) == 0) add_depth(2'($urandom_range(0, 3)));
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        if (len > 2 && k == len / 2 && $urandom_range(0, 7) == 0)
          add_depth(2'($urandom_range(0, 3)));
        add_pixel(PIX_W'($urandom), k == len - 1);
      end
    end
    add_depth(DEPTH_1);
    for (int k = 0; k < 20; k++) add_pixel(PIX_W'($urandom), k == 19);

    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || drv_phase != DRV_LOAD || expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (expect_q.size() != 0)
      $display("%0d expected words never arrived", expect_q.size());

    if (mismatch_cnt == 0 && expect_q.size() == 0) begin
      $display("packed_pixel_doubler_2x_test: done, clean");
    end else begin
      $display("packed_pixel_doubler_2x_test: done, errors");
    end
    $finish;
  end

endmodule
